/* hdl/led_matrix_frame_serializer_unit_defines.svh */
// ----------------------------------------------------------------------------
// LED matrix serializer assertion macros
// Shared property shorthands for the port checker, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAME_SERIALIZER_UNIT_DEFINES_SVH
`define LED_MATRIX_FRAME_SERIALIZER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define LMFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define LMFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset
`define LMFS_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lmfs_pkg.sv */
// ----------------------------------------------------------------------------
// LED matrix serializer package
// Types and constants shared by the front, queue and back sequencer.
// ----------------------------------------------------------------------------
package lmfs_pkg;

    // Width of the frame byte position counter
    localparam int unsigned POS_W = 4;

    // Bus command bytes
    localparam logic [7:0] ADDR_CMD          = 8'hC0;
    localparam logic [7:0] DISPLAY_CMD_RESET = 8'h8A;

    // Depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte handed from front to back
    typedef struct packed {
        logic [7:0] col_byte;
        logic       first;   // byte opens a frame
        logic       last;    // byte closes a frame
    } byte_item_t;

    // Pin sequence segments run by the back sequencer
    typedef enum logic [2:0] {
        SEG_START_A,
        SEG_ADDR,
        SEG_DATA,
        SEG_END_A,
        SEG_START_B,
        SEG_CMD,
        SEG_END_B
    } seg_t;

endpackage

/* hdl/lmfs_front.sv */
// ----------------------------------------------------------------------------
// LED matrix serializer front
// Accepts column bytes, tracks the frame position and tags first/last bytes.
// ----------------------------------------------------------------------------
module lmfs_front #(
    parameter int unsigned FRAME_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] column_byte
    input  logic                q_full,
    output logic                q_push,
    output lmfs_pkg::byte_item_t q_item
);

    localparam logic [lmfs_pkg::POS_W:0] FRAME_LEN = (lmfs_pkg::POS_W + 1)'(FRAME_BYTES);

    logic [lmfs_pkg::POS_W-1:0] pos_reg;
    logic [lmfs_pkg::POS_W-1:0] pos_next;
    logic [lmfs_pkg::POS_W:0]   pos_inc;
    logic                       is_last;

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the byte by its place in the frame
    assign pos_inc = {1'b0, pos_reg} + (lmfs_pkg::POS_W + 1)'(1);
    assign is_last = (pos_inc >= FRAME_LEN);

    assign q_item.col_byte = s_tdata;
    assign q_item.first    = (pos_reg == '0);
    assign q_item.last     = is_last;

    // Advance or wrap the position
    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            pos_next = is_last ? '0 : pos_inc[lmfs_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* hdl/lmfs_queue.sv */
// ----------------------------------------------------------------------------
// LED matrix serializer queue
// Short FIFO of classified bytes between the front and the back sequencer.
// ----------------------------------------------------------------------------
module lmfs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lmfs_pkg::byte_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output lmfs_pkg::byte_item_t head_item
);

    lmfs_pkg::byte_item_t            mem_reg [lmfs_pkg::QUEUE_DEPTH];
    logic [lmfs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [lmfs_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [lmfs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [lmfs_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [lmfs_pkg::QCNT_W-1:0]     count_reg;
    logic [lmfs_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [lmfs_pkg::QCNT_W-1:0] DEPTH_CNT = lmfs_pkg::QCNT_W'(lmfs_pkg::QUEUE_DEPTH);
    localparam logic [lmfs_pkg::QPTR_W-1:0] LAST_PTR  = lmfs_pkg::QPTR_W'(lmfs_pkg::QUEUE_DEPTH - 1);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + lmfs_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + lmfs_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + lmfs_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - lmfs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/lmfs_back.sv */
// ----------------------------------------------------------------------------
// LED matrix serializer back end
// Runs start, byte and end segments and emits one pin step per cycle when not stalled.
// ----------------------------------------------------------------------------
module lmfs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 q_not_empty,
    input  lmfs_pkg::byte_item_t q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] clock_level, [1] data_level, [7:2] zero
    output logic                 m_tlast    // last_step
);

    lmfs_pkg::seg_t seg_reg;
    lmfs_pkg::seg_t seg_next;
    lmfs_pkg::seg_t seg_after;

    logic       active_reg;
    logic       active_next;
    logic [2:0] bit_reg;
    logic [2:0] bit_next;
    logic [1:0] sub_reg;
    logic [1:0] sub_next;
    logic [7:0] val_reg;
    logic       last_reg;
    logic       data_line_reg;
    logic [7:0] disp_cmd_reg;

    logic       out_valid_reg;
    logic       out_clk_reg;
    logic       out_dat_reg;
    logic       out_last_reg;

    logic       advance;
    logic       is_byte_seg;
    logic [7:0] cur_byte;
    logic       seg_end;
    logic       final_step;
    logic       step_clk;
    logic       step_dat;

    // Display command register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_cmd_reg <= lmfs_pkg::DISPLAY_CMD_RESET;
        end else if (cfg_we) begin
            disp_cmd_reg <= cfg_wdata;
        end
    end

    // Step when busy and the output register can take it
    assign advance = active_reg && (!out_valid_reg || m_tready);

    // Decode the current segment
    always_comb begin
        is_byte_seg = 1'b0;
        cur_byte    = val_reg;
        seg_end     = 1'b0;
        step_clk    = 1'b0;
        step_dat    = data_line_reg;
        unique case (seg_reg)
            lmfs_pkg::SEG_START_A, lmfs_pkg::SEG_START_B: begin
                seg_end  = (sub_reg == 2'd2);
                step_clk = 1'b1;
                if (sub_reg == 2'd1) begin
                    step_dat = 1'b1;
                end else if (sub_reg == 2'd2) begin
                    step_dat = 1'b0;
                end
            end
            lmfs_pkg::SEG_END_A, lmfs_pkg::SEG_END_B: begin
                seg_end  = (sub_reg == 2'd3);
                step_clk = sub_reg[1];
                if (sub_reg == 2'd1) begin
                    step_dat = 1'b0;
                end else if (sub_reg == 2'd3) begin
                    step_dat = 1'b1;
                end
            end
            lmfs_pkg::SEG_ADDR, lmfs_pkg::SEG_DATA, lmfs_pkg::SEG_CMD: begin
                is_byte_seg = 1'b1;
                if (seg_reg == lmfs_pkg::SEG_ADDR) begin
                    cur_byte = lmfs_pkg::ADDR_CMD;
                end else if (seg_reg == lmfs_pkg::SEG_CMD) begin
                    cur_byte = disp_cmd_reg;
                end
                seg_end  = (bit_reg == 3'd7) && (sub_reg == 2'd2);
                step_clk = (sub_reg == 2'd2);
                if (sub_reg != 2'd0) begin
                    step_dat = cur_byte[bit_reg];
                end
            end
            default: begin
                seg_end = 1'b1;
            end
        endcase
    end

    // Segment order within one item
    always_comb begin
        seg_after  = lmfs_pkg::SEG_DATA;
        final_step = 1'b0;
        unique case (seg_reg)
            lmfs_pkg::SEG_START_A: seg_after = lmfs_pkg::SEG_ADDR;
            lmfs_pkg::SEG_ADDR:    seg_after = lmfs_pkg::SEG_DATA;
            lmfs_pkg::SEG_DATA: begin
                seg_after  = lmfs_pkg::SEG_END_A;
                final_step = seg_end && !last_reg;
            end
            lmfs_pkg::SEG_END_A:   seg_after = lmfs_pkg::SEG_START_B;
            lmfs_pkg::SEG_START_B: seg_after = lmfs_pkg::SEG_CMD;
            lmfs_pkg::SEG_CMD:     seg_after = lmfs_pkg::SEG_END_B;
            lmfs_pkg::SEG_END_B:   final_step = seg_end;
            default:               final_step = seg_end;
        endcase
    end

    // Load the next item when idle or on the last step of the current one
    assign q_pop = q_not_empty && (!active_reg || (advance && final_step));

    // Next state of the sequencer
    always_comb begin
        seg_next    = seg_reg;
        active_next = active_reg;
        bit_next    = bit_reg;
        sub_next    = sub_reg;
        if (q_pop) begin
            seg_next    = q_head.first ? lmfs_pkg::SEG_START_A : lmfs_pkg::SEG_DATA;
            active_next = 1'b1;
            bit_next    = '0;
            sub_next    = '0;
        end else if (advance) begin
            if (final_step) begin
                active_next = 1'b0;
            end else if (seg_end) begin
                seg_next = seg_after;
                bit_next = '0;
                sub_next = '0;
            end else if (is_byte_seg && (sub_reg == 2'd2)) begin
                sub_next = '0;
                bit_next = bit_reg + 3'd1;
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg       <= lmfs_pkg::SEG_DATA;
            active_reg    <= 1'b0;
            bit_reg       <= '0;
            sub_reg       <= '0;
            data_line_reg <= 1'b0;
        end else begin
            seg_reg    <= seg_next;
            active_reg <= active_next;
            bit_reg    <= bit_next;
            sub_reg    <= sub_next;
            if (advance) begin
                data_line_reg <= step_dat;
            end
        end
    end

    // Hold the byte and its frame tag for the item in work
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            val_reg  <= q_head.col_byte;
            last_reg <= q_head.last;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_clk_reg  <= step_clk;
            out_dat_reg  <= step_dat;
            out_last_reg <= final_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_dat_reg, out_clk_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/led_matrix_frame_serializer_unit.sv */
// A byte's first step reaches m_tvalid via queue, sequencer state and output register.
// One pin step goes out per cycle unless the output stalls; each byte is a data segment,
// plus start/address on opening a frame and end/start/command/end on closing one.
// A two-entry queue lets the front take the next byte while the back is still working.
// Reset (aresetn low, synchronous) clears frame position, data line, queue and output
// valid, and loads the display command with 0x8A.
// ----------------------------------------------------------------------------
// LED matrix frame serializer
// Turns frame column bytes into clock/data pin steps for a two-wire LED driver.
// ----------------------------------------------------------------------------
module led_matrix_frame_serializer_unit #(
    parameter int unsigned FRAME_BYTES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] column_byte
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,  // display_command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [0] clock_level, [1] data_level, [7:2] zero
    output logic       m_tlast     // last_step
);

    lmfs_pkg::byte_item_t push_item;
    lmfs_pkg::byte_item_t head_item;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;

    // Classify incoming bytes
    lmfs_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decouple front and back
    lmfs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // Sequence pin steps
    lmfs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_head      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

/* hdl/lmfs_checker.sv */
// ----------------------------------------------------------------------------
// LED matrix serializer port checker
// Watches the top-level ports for output hold, bus timing and reset rules.
// ----------------------------------------------------------------------------
`include "led_matrix_frame_serializer_unit_defines.svh"

module lmfs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       prev_valid_reg;
    logic       prev_clk_reg;
    logic       prev_dat_reg;
    logic       out_stall;
    logic [8:0] out_word;
    logic       rise_from_low;
    logic       dat_held;
    logic       last_shown;
    logic       clk_high_clean;

    // Qualify the shown output item
    assign out_stall      = m_tvalid && !m_tready;
    assign out_word       = {m_tlast, m_tdata};
    assign rise_from_low  = m_tvalid && prev_valid_reg && !prev_clk_reg && m_tdata[0];
    assign dat_held       = (m_tdata[1] == prev_dat_reg);
    assign last_shown     = m_tvalid && m_tlast;
    assign clk_high_clean = m_tdata[0] && (m_tdata[7:2] == 6'd0);

    // Track the last item taken on the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            prev_valid_reg <= 1'b1;
            prev_clk_reg   <= m_tdata[0];
            prev_dat_reg   <= m_tdata[1];
        end
    end

    // Hold a stalled output item
    `LMFS_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "output not held")

    // Keep data steady across a rising clock
    `LMFS_ASSERT_NOW(a_rise_data, rise_from_low, dat_held, "data changed on rising clock")

    // End every item with the clock high
    `LMFS_ASSERT_NOW(a_last_clk_high, last_shown, clk_high_clean, "last step, clock low")

    // Drop output valid out of reset
    `LMFS_ASSERT_ALWAYS(a_reset_idle, !aresetn, !m_tvalid, "valid after reset")

endmodule

bind led_matrix_frame_serializer_unit lmfs_checker u_lmfs_checker (.*);
